// ===== rtl/mbta_pkg.sv =====
// Package with the constants, types and codes of the multi-buffer trace allocator.
`timescale 1ns / 1ps

package mbta_pkg;

  localparam int BUFFER_COUNT      = 4;
  localparam int BASE_RECORD_BYTES = 16;
  localparam int WORD_BYTES        = 4;

  localparam int IDX_W   = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int HEAD_W  = 20;
  localparam int SIZE_W  = 7;
  localparam int WORDS_W = 5;
  localparam int REL_W   = 5;
  localparam int ARGS_W  = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  typedef logic [IDX_W-1:0]  buf_idx_t;
  typedef logic [HEAD_W-1:0] head_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } state_t;

endpackage

// ===== rtl/multi_buffer_trace_allocator.sv =====
// Top level of the multi-buffer trace allocator: head memory, buffer rotation and result register.
`timescale 1ns / 1ps

// A beat is accepted and the fill head of the active buffer is read from a single-port head
// memory into a register; then, once the output register is free, the record is placed, the
// head is written back and the result is loaded into the output register. A new beat is
// taken while a finished result still waits on the output.
// An allocation that does not fit rotates to the next buffer, in ascending order with wrap,
// whose empty mark is set; if there is none, every later allocation fails until reset.
module multi_buffer_trace_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data,      // buffer_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // arg_count[3:0], release_index[8:4], zero fill
  input  logic        in_tuser,      // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // buffer_index[4:0], byte_offset[24:5],
                                     // record_words[29:25], switched[30], zero fill
  output logic        out_tuser      // granted
);
  import mbta_pkg::*;

  state_t state_r, state_nxt;

  logic [HEAD_W-1:0] buffer_bytes_r;
  buf_idx_t          active_index_r, active_index_nxt;
  logic              active_valid_r, active_valid_nxt;
  logic [BUFFER_COUNT-1:0] empty_marks_r, empty_marks_nxt;
  logic [BUFFER_COUNT-1:0] head_valid_r;

  head_t head_mem [BUFFER_COUNT];
  head_t rd_data_r;
  logic  rd_valid_r;

  logic              op_r;
  logic [ARGS_W-1:0] nargs_r;
  logic [REL_W-1:0]  rel_r;

  logic        out_valid_r;
  logic        out_granted_r;
  logic [4:0]  out_index_r;
  head_t       out_offset_r;
  logic [WORDS_W-1:0] out_words_r;
  logic        out_switched_r;

  logic        in_fire;
  logic        out_free;
  logic        calc_done;

  size_t       size_bytes;
  head_t       head;
  logic [HEAD_W:0] sum_head;
  logic        fits;
  logic        found;
  buf_idx_t    cand;
  logic [IDX_W:0] probe;

  logic        wr_en;
  buf_idx_t    wr_addr;
  head_t       wr_data;

  logic        res_granted;
  buf_idx_t    res_index;
  head_t       res_offset;
  logic        res_switched;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CALC;
      ST_CALC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    calc_done = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CALC: calc_done = out_free;
      default: ;
    endcase
  end

  always_comb begin
    size_bytes = size_t'(BASE_RECORD_BYTES - WORD_BYTES) + size_t'({nargs_r, 2'b00});
    head       = rd_valid_r ? rd_data_r : '0;
    sum_head   = {1'b0, head} + (HEAD_W+1)'(size_bytes);
    fits       = sum_head < {1'b0, buffer_bytes_r};

    found = 1'b0;
    cand  = active_index_r;
    for (int k = 1; k <= BUFFER_COUNT; k++) begin
      probe = (IDX_W+1)'(active_index_r) + (IDX_W+1)'(k);
      if (probe >= (IDX_W+1)'(BUFFER_COUNT)) probe = probe - (IDX_W+1)'(BUFFER_COUNT);
      if (!found && empty_marks_r[probe[IDX_W-1:0]]) begin
        found = 1'b1;
        cand  = probe[IDX_W-1:0];
      end
    end

    active_index_nxt = active_index_r;
    active_valid_nxt = active_valid_r;
    empty_marks_nxt  = empty_marks_r;
    wr_en        = 1'b0;
    wr_addr      = active_index_r;
    wr_data      = sum_head[HEAD_W-1:0];
    res_granted  = 1'b0;
    res_index    = '0;
    res_offset   = '0;
    res_switched = 1'b0;

    if (op_r == OP_RELEASE) begin
      if ({1'b0, rel_r} < (REL_W+1)'(BUFFER_COUNT)) begin
        empty_marks_nxt[rel_r[IDX_W-1:0]] = 1'b1;
      end
    end else if (active_valid_r) begin
      if (fits) begin
        wr_en       = 1'b1;
        res_granted = 1'b1;
        res_index   = active_index_r;
        res_offset  = head;
      end else if (found) begin
        active_index_nxt      = cand;
        empty_marks_nxt[cand] = 1'b0;
        wr_en        = 1'b1;
        wr_addr      = cand;
        wr_data      = head_t'(size_bytes);
        res_granted  = 1'b1;
        res_index    = cand;
        res_switched = 1'b1;
      end else begin
        active_valid_nxt = 1'b0;
      end
    end
  end

  // Head memory: read on acceptance, written back when the beat completes.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= head_mem[active_index_r];
    end
    if (calc_done && wr_en) begin
      head_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      buffer_bytes_r <= 20'd4096;
      active_index_r <= '0;
      active_valid_r <= 1'b1;
      empty_marks_r  <= {{(BUFFER_COUNT-1){1'b1}}, 1'b0};
      head_valid_r   <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        buffer_bytes_r <= cfg_data;
      end
      if (in_fire) begin
        rd_valid_r <= head_valid_r[active_index_r];
      end
      if (calc_done) begin
        active_index_r <= active_index_nxt;
        active_valid_r <= active_valid_nxt;
        empty_marks_r  <= empty_marks_nxt;
        if (wr_en) begin
          head_valid_r[wr_addr] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tuser;
      nargs_r <= in_tdata[3:0];
      rel_r   <= in_tdata[8:4];
    end
    if (calc_done) begin
      out_granted_r  <= res_granted;
      out_index_r    <= 5'(res_index);
      out_offset_r   <= res_offset;
      out_words_r    <= res_granted ? WORDS_W'(size_bytes >> 2) : '0;
      out_switched_r <= res_switched;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_granted_r;
  assign out_tdata  = {1'b0, out_switched_r, out_words_r, out_offset_r, out_index_r};

endmodule

// ===== tb/allocation_checker.sv =====
// Checker for the trace allocator: predicts each grant and compares it with the result beats.
`timescale 1ns / 1ps

module allocation_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [19:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  output int          pending_grants,
  output int          mismatches
);
  import mbta_pkg::*;

  typedef struct packed {
    logic        granted;
    logic [4:0]  buf_idx;
    logic [19:0] offset;
    logic [4:0]  words;
    logic        switched;
  } grant_t;

  int unsigned             buf_limit = 4096;
  int unsigned             active_buf = 0;
  bit                      log_live = 1'b1;
  logic [BUFFER_COUNT-1:0] empty_marks = '1 << 1;
  int unsigned             fill_head [BUFFER_COUNT];
  grant_t                  awaited_grants [$];

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("allocation_checker: %s: got %0d, expected %0d at %0t ns", what, got, want,
               $time);
  endtask

  // Applies one request to the mirrored allocator state and returns the grant it produces.
  function automatic grant_t place_record(op_t op, logic [3:0] nargs, logic [4:0] rel);
    grant_t      g;
    int unsigned size;
    int unsigned head;
    int unsigned head_after;
    int unsigned nxt;
    bit          found;
    g = '0;
    if (op == OP_RELEASE) begin
      if (rel < BUFFER_COUNT) empty_marks[rel[IDX_W-1:0]] = 1'b1;
      return g;
    end
    if (!log_live) return g;
    size = BASE_RECORD_BYTES + WORD_BYTES * nargs - WORD_BYTES;
    head = fill_head[active_buf];
    head_after = head + size;
    if (head_after >= buf_limit) begin
      // The buffers after the active one are searched first; the active one comes last.
      found = 1'b0;
      nxt = active_buf;
      for (int t = 0; t < BUFFER_COUNT && !found; t++) begin
        nxt = (nxt + 1) % BUFFER_COUNT;
        if (empty_marks[nxt]) found = 1'b1;
      end
      if (!found) begin
        log_live = 1'b0;
        return g;
      end
      active_buf = nxt;
      empty_marks[nxt] = 1'b0;
      g.switched = 1'b1;
      head = 0;
      head_after = size;
    end
    fill_head[active_buf] = head_after;
    g.granted = 1'b1;
    g.buf_idx = 5'(active_buf);
    g.offset = 20'(head);
    g.words = 5'(size / WORD_BYTES);
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      buf_limit = 4096;
      active_buf = 0;
      log_live = 1'b1;
      empty_marks = '1 << 1;
      foreach (fill_head[i]) fill_head[i] = 0;
      awaited_grants.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_grants.size() == 0) begin
          report("result beat with no grant awaited", out_tdata, 0);
        end else begin
          want = awaited_grants.pop_front();
          if (out_tuser !== want.granted) report("granted", out_tuser, want.granted);
          if (out_tdata[4:0] !== want.buf_idx)
            report("buffer_index", out_tdata[4:0], want.buf_idx);
          if (out_tdata[24:5] !== want.offset)
            report("byte_offset", out_tdata[24:5], want.offset);
          if (out_tdata[29:25] !== want.words)
            report("record_words", out_tdata[29:25], want.words);
          if (out_tdata[30] !== want.switched) report("switched", out_tdata[30], want.switched);
          if (out_tdata[31] !== 1'b0) report("zero fill", out_tdata[31], 0);
        end
      end
      if (cfg_valid && cfg_ready) buf_limit = 32'(cfg_data);
      if (in_tvalid && in_tready)
        awaited_grants.push_back(place_record(op_t'(in_tuser), in_tdata[3:0], in_tdata[8:4]));
    end
    pending_grants <= awaited_grants.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the trace allocator: clock, reset, request and result traffic and the verdict.
`timescale 1ns / 1ps

module tb;
  import mbta_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [19:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_ready;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic        out_tuser;

  int pending_grants;
  int mismatches;
  int out_beats = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit gappy = 1'b1;
  bit held = 1'b0;

  multi_buffer_trace_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  allocation_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .pending_grants(pending_grants),
    .mismatches    (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) out_beats <= out_beats + 1;
  end

  task automatic offer(input op_t op, input logic [3:0] nargs, input logic [4:0] rel);
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'b0, rel, nargs};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_grants != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [19:0] bytes);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= bytes;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A release of some buffer, then allocations that sum below the buffer size (bar a first one
  // that alone reaches it): at most one rotation happens and it always finds a marked buffer.
  task automatic fill_run(input int unsigned lim);
    int unsigned k;
    int unsigned total;
    int unsigned size;
    logic [3:0]  nargs;
    gappy = ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 4) == 0)
      offer(OP_RELEASE, 4'($urandom), 5'($urandom_range(BUFFER_COUNT, 31)));
    if ($urandom_range(0, 5) == 0) offer(OP_RELEASE, 4'($urandom), 5'($urandom_range(0, 31)));
    offer(OP_RELEASE, 4'($urandom), 5'($urandom_range(0, BUFFER_COUNT - 1)));
    k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
    total = 0;
    for (int i = 0; i < k; i++) begin
      nargs = 4'($urandom);
      size = BASE_RECORD_BYTES + WORD_BYTES * nargs - WORD_BYTES;
      if (i > 0 && total + size >= lim) break;
      total += size;
      offer(OP_ALLOC, nargs, 5'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned limits [8];
    int          mark;
    limits = '{40, 1048568, 16, 20'hFFFFF, 0, 100, 4096, 8 * $urandom_range(2, 128)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    offer(OP_ALLOC, 4'd0, 5'd0);
    offer(OP_ALLOC, 4'd15, 5'd31);
    offer(OP_RELEASE, 4'd15, 5'd31);
    offer(OP_RELEASE, 4'd0, 5'd4);
    offer(OP_RELEASE, 4'd0, 5'd0);
    offer(OP_ALLOC, 4'd7, 5'd0);
    write_limit(20'd16);
    offer(OP_ALLOC, 4'd15, 5'd0);
    offer(OP_ALLOC, 4'd0, 5'd0);
    offer(OP_ALLOC, 4'd0, 5'd0);
    offer(OP_ALLOC, 4'd0, 5'd0);
    offer(OP_RELEASE, 4'd0, 5'd1);
    offer(OP_ALLOC, 4'd0, 5'd0);
    offer(OP_RELEASE, 4'd0, 5'd1);
    offer(OP_ALLOC, 4'd0, 5'd0);
    write_limit(20'd0);
    offer(OP_RELEASE, 4'd0, 5'd3);
    offer(OP_ALLOC, 4'd4, 5'd0);
    write_limit(20'hFFFFF);
    offer(OP_ALLOC, 4'd15, 5'd0);

    foreach (limits[p]) begin
      write_limit(20'(limits[p]));
      mark = sent;
      while (sent < mark + 156) fill_run(limits[p]);
    end

    // Without releases the marks run out and the log stays dead even after later releases.
    calm = 1'b1;
    write_limit(20'd16);
    repeat (6) offer(OP_ALLOC, 4'($urandom), 5'($urandom));
    for (int i = 0; i < BUFFER_COUNT; i++) offer(OP_RELEASE, 4'($urandom), 5'(i));
    repeat (4) offer(OP_ALLOC, 4'($urandom), 5'($urandom));

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : drain
    int span;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && out_beats >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
